// File: rtl/core/kap_pkg.sv
// ----------------------------------------------------------------------------
// kap_pkg - shared types and constants of the angle predictor
// Word format, operation codes, register indexes and shared-unit operations.
// ----------------------------------------------------------------------------
package kap_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam int CFG_IDX_WIDTH = 3;
    localparam logic [2:0] REG_Q_POS     = 3'd0;
    localparam logic [2:0] REG_Q_VEL     = 3'd1;
    localparam logic [2:0] REG_R_MEAS    = 3'd2;
    localparam logic [2:0] REG_DT        = 3'd3;
    localparam logic [2:0] REG_LEAD_TIME = 3'd4;
    localparam logic [2:0] REG_SPARE     = 3'd7;

    localparam int REG_WIDTH = 31;

    // shared-unit operations
    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_ADD = 2'd1,
        ALU_SUB = 2'd2
    } alu_op_t;

endpackage

// File: rtl/core/kap_div.sv
// ----------------------------------------------------------------------------
// kap_div - radix-2 fixed-point divider
// Signed quotient n/d with FRAC_BITS fraction bits, truncated toward zero
// and saturated to the word; zero divisor gives zero. One bit per cycle.
// ----------------------------------------------------------------------------
module kap_div #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [WORD_WIDTH-1:0] num,
    input  logic signed [WORD_WIDTH-1:0] den,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] quot
);
    localparam int STEPS = WORD_WIDTH + FRAC_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [WORD_WIDTH-1:0] un_reg, ud_reg;
    logic [WORD_WIDTH:0]   r_reg;
    logic [WORD_WIDTH:0]   q_reg;
    logic                  neg_reg, busy_reg, zero_reg;
    logic [CW-1:0]         cnt_reg;
    logic [WORD_WIDTH:0]   limit;
    logic [WORD_WIDTH:0]   r_sh, q_sh, q_new;
    logic                  bit_in;

    assign limit = neg_reg ? (WORD_WIDTH+1)'(1) << (WORD_WIDTH-1)
                           : ((WORD_WIDTH+1)'(1) << (WORD_WIDTH-1)) - 1'b1;
    assign bit_in = (cnt_reg > CW'(FRAC_BITS)) ? un_reg[WORD_WIDTH-1] : 1'b0;
    assign r_sh  = {r_reg[WORD_WIDTH-1:0], bit_in};
    assign q_sh  = {q_reg[WORD_WIDTH-1:0], 1'b0};

    always_comb begin
        q_new = q_sh;
        if (r_sh >= {1'b0, ud_reg}) begin
            q_new = q_sh | (WORD_WIDTH+1)'(1);
        end
        if (q_new > limit) begin
            q_new = limit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
                neg_reg  <= num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
                un_reg   <= num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : WORD_WIDTH'(num);
                ud_reg   <= den[WORD_WIDTH-1] ? WORD_WIDTH'(-den) : WORD_WIDTH'(den);
                zero_reg <= (den == '0);
                r_reg    <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                if (cnt_reg > CW'(FRAC_BITS)) begin
                    un_reg <= {un_reg[WORD_WIDTH-2:0], 1'b0};
                end
                r_reg   <= (r_sh >= {1'b0, ud_reg}) ? r_sh - {1'b0, ud_reg} : r_sh;
                q_reg   <= q_new;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (zero_reg) begin
            quot = '0;
        end else if (neg_reg) begin
            quot = WORD_WIDTH'(-$signed({1'b0, q_reg}));
        end else begin
            quot = WORD_WIDTH'(q_reg);
        end
    end
endmodule

// File: rtl/core/kap_alu.sv
// ----------------------------------------------------------------------------
// kap_alu - shared arithmetic unit
// Registered rounded saturating fixed-point multiply, saturating add and
// subtract. Result registered, valid in the cycle after the operands.
// ----------------------------------------------------------------------------
module kap_alu #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  kap_pkg::alu_op_t             op,
    input  logic signed [WORD_WIDTH-1:0] a,
    input  logic signed [WORD_WIDTH-1:0] b,
    output logic signed [WORD_WIDTH-1:0] y_reg
);
    localparam int PW = 2 * WORD_WIDTH;
    localparam logic signed [PW:0] WMAX = (PW+1)'((64'(1) << (WORD_WIDTH-1)) - 1);
    localparam logic signed [PW:0] WMIN = -WMAX - 1;

    logic signed [PW-1:0] prod;
    logic signed [PW:0]   wide;
    logic signed [PW:0]   mag_r;
    logic signed [WORD_WIDTH-1:0] y_next;

    assign prod = a * b;

    always_comb begin
        wide = '0;
        mag_r = '0;
        case (op)
            kap_pkg::ALU_MUL: begin
                mag_r = prod[PW-1] ? -(PW+1)'(prod) : (PW+1)'(prod);
                mag_r = (mag_r + ((PW+1)'(1) << (FRAC_BITS-1))) >>> FRAC_BITS;
                wide  = prod[PW-1] ? -mag_r : mag_r;
            end
            kap_pkg::ALU_ADD: wide = (PW+1)'(a) + (PW+1)'(b);
            kap_pkg::ALU_SUB: wide = (PW+1)'(a) - (PW+1)'(b);
            default:          wide = '0;
        endcase
        if (wide > WMAX) begin
            y_next = WORD_WIDTH'(WMAX);
        end else if (wide < WMIN) begin
            y_next = WORD_WIDTH'(WMIN);
        end else begin
            y_next = WORD_WIDTH'(wide);
        end
    end

    always_ff @(posedge aclk) begin
        y_reg <= y_next;
    end
endmodule

// File: rtl/core/kalman_angle_predictor.sv
// ----------------------------------------------------------------------------
// kalman_angle_predictor - two-state Kalman angle filter with lead
// Sequencer drives one shared multiply/add unit and one serial divider.
// ----------------------------------------------------------------------------
// A measure beat runs through the shared-unit steps and two serial divisions
// before its result is registered; a clear beat gives no result.
// One beat in flight at a time.
// Result waits in an output register; s_tready returns once it is taken.
// Reset (aresetn low, synchronous): registers to defaults, covariance all 1000.
module kalman_angle_predictor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // angle_meas[31:0]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // predicted_angle[31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int WORD_WIDTH = kap_pkg::WORD_WIDTH;
    localparam int FRAC_BITS  = kap_pkg::FRAC_BITS;
    localparam int W = WORD_WIDTH;
    typedef logic signed [W-1:0] word_t;
    localparam logic signed [W:0] WMAX = (W+1)'((64'(1) << (W-1)) - 1);
    localparam logic signed [W+1:0] ACC_MAX = (W+2)'(WMAX);
    localparam logic signed [W+1:0] ACC_MIN = -ACC_MAX - (W+2)'(1);
    localparam word_t ONE = word_t'(64'(1) << FRAC_BITS);
    localparam word_t HALF = word_t'(64'(1) << (FRAC_BITS-1));
    localparam logic signed [W+10:0] K1000 = (W+11)'(1000) <<< FRAC_BITS;
    localparam word_t P_INIT = (K1000 > (W+11)'(WMAX)) ? word_t'(WMAX) : word_t'(K1000);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ALU  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_CLR  = 5'b10000
    } state_t;

    logic [30:0] q_pos_reg, q_vel_reg, r_meas_reg, dt_reg, lead_reg;
    word_t xa_reg, xr_reg, prev_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    word_t z_reg, t_reg, n01_reg, n10_reg, n11_reg, n00_reg, s_reg, k0_reg, k1_reg,
           e_reg, xpa_reg, omk_reg, rt_reg;
    logic signed [W+1:0] acc_reg;
    state_t state_reg;
    logic [4:0] step_reg;
    logic div_sel_reg, div_go_reg, div_go_next;
    logic [31:0] out_reg;

    kap_pkg::alu_op_t op;
    word_t a, b, y;
    word_t quot;
    logic  div_done;
    word_t d_w, qp_w, qv_w, r_w, lt_w;

    assign d_w  = word_t'(dt_reg);
    assign qp_w = word_t'(q_pos_reg);
    assign qv_w = word_t'(q_vel_reg);
    assign r_w  = word_t'(r_meas_reg);
    assign lt_w = word_t'(lead_reg);

    kap_alu #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_alu (
        .aclk(aclk), .op(op), .a(a), .b(b), .y_reg(y)
    );

    kap_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .num(div_sel_reg ? n10_reg : n00_reg), .den(s_reg),
        .done(div_done), .quot(quot)
    );

    // step issues op in cycle of step; result lands next cycle (step+1 reads y)
    always_comb begin
        op = kap_pkg::ALU_MUL; a = d_w; b = p11_reg;
        case (step_reg)
            5'd0:  begin op = kap_pkg::ALU_MUL; a = d_w;     b = p11_reg; end
            5'd1:  begin op = kap_pkg::ALU_ADD; a = p01_reg; b = y;       end
            5'd2:  begin op = kap_pkg::ALU_ADD; a = p10_reg; b = t_reg;   end
            5'd3:  begin op = kap_pkg::ALU_ADD; a = p11_reg; b = qv_w;    end
            5'd4:  begin op = kap_pkg::ALU_MUL; a = d_w;     b = p10_reg; end
            5'd5:  begin op = kap_pkg::ALU_MUL; a = d_w;     b = n01_reg; end
            5'd8:  begin op = kap_pkg::ALU_MUL; a = d_w;     b = xr_reg;  end
            5'd9:  begin op = kap_pkg::ALU_ADD; a = xa_reg;  b = y;       end
            5'd10: begin op = kap_pkg::ALU_ADD; a = n00_reg; b = r_w;     end
            5'd11: begin op = kap_pkg::ALU_SUB; a = z_reg;   b = xpa_reg; end
            5'd12: begin op = kap_pkg::ALU_MUL; a = k0_reg;  b = e_reg;   end
            5'd13: begin op = kap_pkg::ALU_ADD; a = xpa_reg; b = y;       end
            5'd14: begin op = kap_pkg::ALU_MUL; a = k1_reg;  b = e_reg;   end
            5'd15: begin op = kap_pkg::ALU_ADD; a = xr_reg;  b = y;       end
            5'd16: begin op = kap_pkg::ALU_SUB; a = ONE;     b = k0_reg;  end
            5'd17: begin op = kap_pkg::ALU_MUL; a = y;       b = n00_reg; end
            5'd18: begin op = kap_pkg::ALU_MUL; a = omk_reg; b = n01_reg; end
            5'd19: begin op = kap_pkg::ALU_MUL; a = k1_reg;  b = n00_reg; end
            5'd20: begin op = kap_pkg::ALU_SUB; a = n10_reg; b = y;       end
            5'd21: begin op = kap_pkg::ALU_MUL; a = k1_reg;  b = n01_reg; end
            5'd22: begin op = kap_pkg::ALU_SUB; a = n11_reg; b = y;       end
            5'd23: begin op = kap_pkg::ALU_MUL; a = rt_reg;  b = lt_w;    end
            5'd24: begin op = kap_pkg::ALU_ADD; a = xa_reg;  b = y;       end
            default: begin op = kap_pkg::ALU_MUL; a = d_w; b = p11_reg; end
        endcase
    end

    logic signed [W:0] jump;
    assign jump = (W+1)'(xr_reg) - (W+1)'(prev_reg);

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = out_reg;

    // first division kicked at step 12, second once the first is done
    assign div_go_next = !div_sel_reg &&
                         ((state_reg == ST_ALU && step_reg == 5'd12) ||
                          (state_reg == ST_DIV && div_done));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            div_sel_reg <= 1'b0;
            div_go_reg <= 1'b0;
            q_pos_reg  <= 31'd66;
            q_vel_reg  <= 31'd66;
            r_meas_reg <= 31'd65536;
            dt_reg     <= 31'd65536;
            lead_reg   <= '0;
            xa_reg     <= '0;
            xr_reg     <= '0;
            prev_reg   <= '0;
            p00_reg    <= P_INIT;
            p01_reg    <= P_INIT;
            p10_reg    <= P_INIT;
            p11_reg    <= P_INIT;
        end else begin
            div_go_reg <= div_go_next;
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        case (cfg_index)
                            kap_pkg::REG_Q_POS:     q_pos_reg  <= cfg_data[30:0];
                            kap_pkg::REG_Q_VEL:     q_vel_reg  <= cfg_data[30:0];
                            kap_pkg::REG_R_MEAS:    r_meas_reg <= cfg_data[30:0];
                            kap_pkg::REG_DT:        dt_reg     <= cfg_data[30:0];
                            kap_pkg::REG_LEAD_TIME: lead_reg   <= cfg_data[30:0];
                            default: ;
                        endcase
                    end else if (s_tvalid) begin
                        if (s_tuser == kap_pkg::OP_CLEAR) begin
                            state_reg <= ST_CLR;
                        end else begin
                            z_reg     <= word_t'($signed(s_tdata));
                            step_reg  <= '0;
                            state_reg <= ST_ALU;
                        end
                    end
                end
                ST_CLR: begin
                    xa_reg <= '0; xr_reg <= '0;
                    p00_reg <= P_INIT; p01_reg <= '0; p10_reg <= '0; p11_reg <= P_INIT;
                    state_reg <= ST_IDLE;
                end
                ST_ALU: begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        5'd1:  t_reg   <= y;
                        5'd2:  n01_reg <= y;
                        5'd3:  n10_reg <= y;
                        5'd4:  n11_reg <= y;
                        // P00 summed wide, saturated once
                        5'd5:  acc_reg <= (W+2)'(p00_reg) + (W+2)'(y);
                        5'd6:  acc_reg <= acc_reg + (W+2)'(y) + (W+2)'(qp_w);
                        5'd7: begin
                            if (acc_reg > ACC_MAX) n00_reg <= word_t'(ACC_MAX);
                            else if (acc_reg < ACC_MIN) n00_reg <= word_t'(ACC_MIN);
                            else n00_reg <= word_t'(acc_reg);
                        end
                        5'd10: xpa_reg <= y;
                        5'd11: begin
                            s_reg <= y;
                            div_sel_reg <= 1'b0;
                        end
                        5'd12: begin
                            if (!div_sel_reg) begin
                                e_reg <= y;
                                state_reg <= ST_DIV;
                            end
                        end
                        5'd14: xa_reg  <= y;
                        5'd16: xr_reg  <= y;
                        5'd17: begin
                            omk_reg  <= y;
                            prev_reg <= xr_reg;
                            rt_reg   <= (jump > (W+1)'(HALF) || jump < -(W+1)'(HALF))
                                        ? '0 : xr_reg;
                        end
                        5'd18: p00_reg <= y;
                        5'd19: p01_reg <= y;
                        5'd21: p10_reg <= y;
                        5'd23: p11_reg <= y;
                        5'd25: begin
                            if ((W+1)'(y) > (W+1)'(33'sh7fffffff)) out_reg <= 32'h7fffffff;
                            else if ((W+1)'(y) < -(W+1)'(33'sh80000000))
                                out_reg <= 32'h80000000;
                            else out_reg <= 32'(y);
                            state_reg <= ST_OUT;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (!div_sel_reg) begin
                            k0_reg <= quot;
                            div_sel_reg <= 1'b1;
                        end else begin
                            k1_reg <= quot;
                            step_reg <= 5'd12;
                            state_reg <= ST_ALU;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----------------------------------------------------------------------------
// kalman_angle_predictor_checker - port protocol checks
// Result beat held under back-pressure, one beat in flight, clean handshakes.
// ----------------------------------------------------------------------------
module kalman_angle_predictor_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after an accepted beat");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result beat waits");

    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tready, m_tvalid, cfg_ready}))
        else $error("handshake output unknown");
endmodule

bind kalman_angle_predictor kalman_angle_predictor_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);

// File: tb/kalman_angle_predictor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kalman_angle_predictor_tb - self-checking bench for the angle predictor
// A queued driver feeds measure and clear beats with random gaps, a monitor
// takes results under random back-pressure and checks each one against a
// fixed-point predictor of the filter step. Registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module kalman_angle_predictor_tb;

    localparam int FB = 16;
    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;
    localparam logic signed [63:0] ONE_Q = 64'sd65536;
    localparam logic signed [63:0] HALF_Q = 64'sd32768;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    kalman_angle_predictor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic        op;
        logic [31:0] angle;
    } beat_t;

    beat_t       pending_beats[$];
    logic [31:0] angle_expected[$];
    int          errors = 0;
    int          results_seen = 0;
    int          clears_sent = 0;
    bit          quiet = 1'b0;

    // predictor state
    logic signed [63:0] k_qpos, k_qvel, k_rmeas, k_dt, k_lead;
    logic signed [63:0] x_ang, x_rate, x_prev;
    logic signed [63:0] cov[4];

    function automatic logic signed [63:0] sat_w(logic signed [63:0] x);
        if (x > WMAX) return WMAX;
        if (x < WMIN) return WMIN;
        return x;
    endfunction

    // exact product, round half away from zero, saturate
    function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
        logic neg;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = (p + (128'd1 << (FB - 1))) >> FB;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (p > lim) p = lim;
        return neg ? -$signed(64'(p)) : $signed(64'(p));
    endfunction

    // truncating quotient, saturate; zero divisor gives zero
    function automatic logic signed [63:0] qdiv(logic signed [63:0] n, logic signed [63:0] d);
        logic neg;
        logic [127:0] q;
        logic [127:0] lim;
        if (d == 0) return 0;
        neg = (n < 0) != (d < 0);
        q = (128'(n < 0 ? -n : n) << FB) / 128'(d < 0 ? -d : d);
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (q > lim) q = lim;
        return neg ? -$signed(64'(q)) : $signed(64'(q));
    endfunction

    task automatic filter_clear();
        x_ang = 0;
        x_rate = 0;
        cov[0] = 1000 * ONE_Q;
        cov[1] = 0;
        cov[2] = 0;
        cov[3] = 1000 * ONE_Q;
    endtask

    task automatic filter_step(beat_t b);
        logic signed [63:0] z, t, p00, p01, p10, p11, xa, s, k0, k1, e, omk, rt, res;
        if (b.op == kap_pkg::OP_CLEAR) begin
            filter_clear();
            return;
        end
        z = 64'($signed(b.angle));
        t = qmul(k_dt, cov[3]);
        p01 = sat_w(cov[1] + t);
        p10 = sat_w(cov[2] + t);
        p11 = sat_w(cov[3] + k_qvel);
        p00 = sat_w(cov[0] + qmul(k_dt, cov[2]) + qmul(k_dt, p01) + k_qpos);
        xa = sat_w(x_ang + qmul(k_dt, x_rate));
        s = sat_w(p00 + k_rmeas);
        k0 = qdiv(p00, s);
        k1 = qdiv(p10, s);
        e = sat_w(z - xa);
        x_ang = sat_w(xa + qmul(k0, e));
        x_rate = sat_w(x_rate + qmul(k1, e));
        omk = sat_w(ONE_Q - k0);
        cov[0] = qmul(omk, p00);
        cov[1] = qmul(omk, p01);
        cov[2] = sat_w(p10 - qmul(k1, p00));
        cov[3] = sat_w(p11 - qmul(k1, p01));
        rt = x_rate;
        t = x_rate - x_prev;
        x_prev = x_rate;
        if (t > HALF_Q || t < -HALF_Q) rt = 0;
        res = sat_w(x_ang + qmul(rt, k_lead));
        angle_expected.push_back(res[31:0]);
    endtask

    // driver
    int src_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                filter_step(beat_t'{s_tuser, s_tdata});
                void'(pending_beats.pop_front());
            end
            if (s_tvalid && !s_tready) begin
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                beat_t nb;
                nb = pending_beats[0];
                s_tvalid <= 1'b1;
                s_tuser <= nb.op;
                s_tdata <= nb.angle;
                if (!quiet && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int sink_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (angle_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    logic [31:0] want;
                    want = angle_expected.pop_front();
                    if (want !== m_tdata) begin
                        errors++;
                        $display("%0t: predicted_angle mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                    end
                end
            end
            if (quiet) begin
                m_tready <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) sink_gap <= $urandom_range(1, 14);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            kap_pkg::REG_Q_POS:     k_qpos = 64'(val[30:0]);
            kap_pkg::REG_Q_VEL:     k_qvel = 64'(val[30:0]);
            kap_pkg::REG_R_MEAS:    k_rmeas = 64'(val[30:0]);
            kap_pkg::REG_DT:        k_dt = 64'(val[30:0]);
            kap_pkg::REG_LEAD_TIME: k_lead = 64'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_tvalid || angle_expected.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_beat(logic op, logic [31:0] a);
        pending_beats.push_back(beat_t'{op, a});
        if (op == kap_pkg::OP_CLEAR) clears_sent++;
    endtask

    // small angles, slow tracks; mostly well-formed motion
    task automatic random_phase(int n);
        logic [31:0] a;
        int rate;
        a = $urandom_range(0, 65536 * 40) - 65536 * 20;
        rate = int'($urandom_range(0, 40000)) - 20000;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: push_beat(kap_pkg::OP_CLEAR, $urandom());
                1, 2: push_beat(kap_pkg::OP_MEASURE, $urandom());
                default: begin
                    a = a + rate + int'($urandom_range(0, 8000)) - 4000;
                    push_beat(kap_pkg::OP_MEASURE, a);
                end
            endcase
        end
    endtask

    task automatic random_regs();
        write_reg(kap_pkg::REG_Q_POS, $urandom_range(0, 4000));
        write_reg(kap_pkg::REG_Q_VEL, $urandom_range(0, 4000));
        write_reg(kap_pkg::REG_R_MEAS, $urandom_range(1, 65536 * 8));
        write_reg(kap_pkg::REG_DT, $urandom_range(0, 65536 * 2));
        write_reg(kap_pkg::REG_LEAD_TIME, $urandom_range(0, 65536 * 4));
    endtask

    initial begin
        k_qpos = 66; k_qvel = 66; k_rmeas = 65536; k_dt = 65536; k_lead = 0;
        x_prev = 0;
        filter_clear();
        cov[1] = 1000 * ONE_Q;
        cov[2] = 1000 * ONE_Q;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset defaults, field extremes, clears, rate jumps
        push_beat(kap_pkg::OP_MEASURE, 32'h0000_0000);
        push_beat(kap_pkg::OP_MEASURE, 32'h7fff_ffff);
        push_beat(kap_pkg::OP_MEASURE, 32'h8000_0000);
        push_beat(kap_pkg::OP_MEASURE, 32'hffff_ffff);
        push_beat(kap_pkg::OP_CLEAR, 32'hffff_ffff);
        push_beat(kap_pkg::OP_MEASURE, 32'h0001_0000);
        push_beat(kap_pkg::OP_MEASURE, 32'h0002_0000);
        push_beat(kap_pkg::OP_CLEAR, 32'h0000_0000);
        wait_idle();

        write_reg(kap_pkg::REG_LEAD_TIME, 32'hffff_ffff);
        write_reg(kap_pkg::REG_DT, 32'h7fff_ffff);
        write_reg(kap_pkg::REG_Q_POS, 32'h7fff_ffff);
        write_reg(kap_pkg::REG_Q_VEL, 32'h7fff_ffff);
        write_reg(kap_pkg::REG_R_MEAS, 32'h7fff_ffff);
        write_reg(kap_pkg::REG_SPARE, 32'h1234_5678);
        push_beat(kap_pkg::OP_MEASURE, 32'h4000_0000);
        push_beat(kap_pkg::OP_MEASURE, 32'hc000_0000);
        push_beat(kap_pkg::OP_CLEAR, 32'h0);
        push_beat(kap_pkg::OP_MEASURE, 32'h0000_8000);
        wait_idle();

        // small measurement variance: R_MEAS = 1, no process noise, dt = 0
        write_reg(kap_pkg::REG_Q_POS, 0);
        write_reg(kap_pkg::REG_Q_VEL, 0);
        write_reg(kap_pkg::REG_DT, 0);
        write_reg(kap_pkg::REG_R_MEAS, 1);
        write_reg(kap_pkg::REG_LEAD_TIME, 65536);
        push_beat(kap_pkg::OP_CLEAR, 0);
        push_beat(kap_pkg::OP_MEASURE, 32'h0003_0000);
        push_beat(kap_pkg::OP_MEASURE, 32'h0003_1000);
        push_beat(kap_pkg::OP_MEASURE, 32'hfffd_0000);
        push_beat(kap_pkg::OP_MEASURE, 32'h0000_0001);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            random_regs();
            random_phase(95);
            wait_idle();
        end

        write_reg(kap_pkg::REG_Q_POS, 66);
        write_reg(kap_pkg::REG_R_MEAS, 65536);
        write_reg(kap_pkg::REG_DT, 65536);
        quiet = 1'b1;
        random_phase(30);
        wait_idle();

        $display("covered %0d results and %0d clear beats over several register settings",
                 results_seen, clears_sent);
        if (errors == 0 && angle_expected.size() == 0) begin
            $display("kalman_angle_predictor_tb: clean");
        end else begin
            $display("kalman_angle_predictor_tb: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("kalman_angle_predictor_tb: errors");
        $finish;
    end
endmodule
